// ===== design/lzwgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwgc_pkg: shared types and constants of the greedy LZ window compressor
// Word formats, configuration register indexes, token sizes, sequencer states.
// ----------------------------------------------------------------------------
package lzwgc_pkg;

  // input word: one uncompressed byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_block;
  } in_word_t;

  // output word: one token
  typedef struct packed {
    logic [1:0] token_byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       block_done;
  } out_word_t;

  // configuration register indexes
  localparam logic CFG_MARKER_BYTE = 1'b0;
  localparam logic CFG_MIN_MATCH   = 1'b1;

  // token sizes
  localparam logic [1:0] TOK_LITERAL = 2'd1;
  localparam logic [1:0] TOK_ESCAPE  = 2'd2;
  localparam logic [1:0] TOK_MATCH   = 2'd3;

  localparam logic [7:0] ESCAPE_CODE = 8'h00;
  localparam logic [7:0] MARKER_RESET = 8'd255;
  localparam logic [6:0] MIN_MATCH_RESET = 7'd3;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_CHECK     = 10'b00_0000_0010,
    ST_SCAN_RD   = 10'b00_0000_0100,
    ST_SCAN_CMP  = 10'b00_0000_1000,
    ST_NEXT      = 10'b00_0001_0000,
    ST_DECIDE    = 10'b00_0010_0000,
    ST_TOK       = 10'b00_0100_0000,
    ST_EMIT      = 10'b00_1000_0000,
    ST_COMMIT_RD = 10'b01_0000_0000,
    ST_COMMIT_WR = 10'b10_0000_0000
  } state_t;

endpackage

// ===== design/lz_window_greedy_compressor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_window_greedy_compressor_unit: greedy LZ77 byte compressor
// Byte in, token out (literal, escaped marker, or marker/offset/length).
// ----------------------------------------------------------------------------
//  channel | ports                        | word
//  in      | in_valid, in_stall, in_word  | data byte, end of block flag
//  out     | out_valid, out_stall, out_word | one token of 1..3 bytes
//  cfg     | cfg_we, cfg_index, cfg_wdata | marker byte, min match length
//
// One byte is taken per pass; in_stall stays high while tokens are coded.
// Coding a token walks every window offset through one shared byte comparator,
// reading and comparing one byte at a time until a mismatch or the length limit;
// the token is then set up and emitted, and each consumed byte is moved into
// history by a read step and a write step; the history RAM read port sets the pace.
// rst_n is synchronous; history and lookahead RAMs are not cleared.
// A token waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module lz_window_greedy_compressor_unit #(
  parameter int WINDOW_BYTES    = 255,
  parameter int MAX_MATCH_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lzwgc_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lzwgc_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_MATCH_BYTES + 1);
  localparam int LA_AW = (MAX_MATCH_BYTES > 1) ? $clog2(MAX_MATCH_BYTES) : 1;
  localparam int LA_DEPTH = 2 ** LA_AW;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_MATCH_BYTES);
  localparam logic [7:0] FILL_MAX = 8'(WINDOW_BYTES);

  lzwgc_pkg::state_t state_r, state_nxt;

  logic [7:0]       marker_r, marker_nxt;
  logic [6:0]       min_match_r, min_match_nxt;
  logic [7:0]       wp_r, wp_nxt;
  logic [7:0]       fill_r, fill_nxt;
  logic [LA_AW-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       d_r, d_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] best_len_r, best_len_nxt;
  logic [7:0]       best_off_r, best_off_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  lzwgc_pkg::out_word_t tok_r, tok_nxt;
  lzwgc_pkg::out_word_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             hist_we;
  logic [7:0]       hist_raddr;
  logic [7:0]       hist_q;
  logic             la_we;
  logic [LA_AW-1:0] la_waddr;
  logic [LA_AW-1:0] la_raddr;
  logic [7:0]       la_q;
  logic [7:0]       lim;
  logic [7:0]       min_eff;

  // history window and lookahead storage
  lzwgc_ram #(.WIDTH(8), .DEPTH(256)) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(wp_r),
    .wdata(la_q),
    .raddr(hist_raddr),
    .rdata(hist_q)
  );

  lzwgc_ram #(.WIDTH(8), .DEPTH(LA_DEPTH)) u_look (
    .clk  (clk),
    .we   (la_we),
    .waddr(la_waddr),
    .wdata(in_word.data_byte),
    .raddr(la_raddr),
    .rdata(la_q)
  );

  // match length limit: offset distance or bytes queued
  assign lim = (d_r < 8'(cnt_r)) ? d_r : 8'(cnt_r);
  assign min_eff = (min_match_r == 7'd0) ? 8'd1 : {1'b0, min_match_r};

  assign hist_raddr = wp_r - d_r + 8'(len_r);
  assign la_waddr   = head_r + LA_AW'(cnt_r);
  assign la_raddr   = (state_r == lzwgc_pkg::ST_SCAN_RD) ? head_r + LA_AW'(len_r) : head_r;
  assign la_we      = (state_r == lzwgc_pkg::ST_IDLE) && in_valid && (cnt_r < CNT_FULL);
  assign hist_we    = (state_r == lzwgc_pkg::ST_COMMIT_WR);

  assign in_stall  = (state_r != lzwgc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    marker_nxt    = marker_r;
    min_match_nxt = min_match_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    d_nxt         = d_r;
    len_nxt       = len_r;
    best_len_nxt  = best_len_r;
    best_off_nxt  = best_off_r;
    n_nxt         = n_r;
    tok_nxt       = tok_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cfg_we) begin
      if (cfg_index == lzwgc_pkg::CFG_MARKER_BYTE) begin
        marker_nxt = cfg_wdata;
      end else begin
        min_match_nxt = cfg_wdata[6:0];
      end
    end

    unique case (state_r)
      lzwgc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (cnt_r < CNT_FULL) cnt_nxt = cnt_r + 1'b1;
          last_nxt  = in_word.end_of_block;
          state_nxt = lzwgc_pkg::ST_CHECK;
        end
      end
      lzwgc_pkg::ST_CHECK: begin
        // start a token on full lookahead, or flush at block end
        if ((last_r && cnt_r != '0) || (!last_r && cnt_r == CNT_FULL)) begin
          best_len_nxt = '0;
          best_off_nxt = '0;
          len_nxt      = '0;
          d_nxt        = fill_r;
          state_nxt    = (fill_r == 8'd0) ? lzwgc_pkg::ST_DECIDE : lzwgc_pkg::ST_SCAN_RD;
        end else begin
          if (last_r) fill_nxt = 8'd0;
          state_nxt = lzwgc_pkg::ST_IDLE;
        end
      end
      lzwgc_pkg::ST_SCAN_RD: begin
        state_nxt = (8'(len_r) < lim) ? lzwgc_pkg::ST_SCAN_CMP : lzwgc_pkg::ST_NEXT;
      end
      lzwgc_pkg::ST_SCAN_CMP: begin
        if (hist_q == la_q) begin
          len_nxt   = len_r + 1'b1;
          state_nxt = lzwgc_pkg::ST_SCAN_RD;
        end else begin
          state_nxt = lzwgc_pkg::ST_NEXT;
        end
      end
      lzwgc_pkg::ST_NEXT: begin
        // strictly longer wins, so the larger offset keeps ties
        if (len_r > best_len_r) begin
          best_len_nxt = len_r;
          best_off_nxt = d_r;
        end
        d_nxt     = d_r - 8'd1;
        len_nxt   = '0;
        state_nxt = (d_r == 8'd1) ? lzwgc_pkg::ST_DECIDE : lzwgc_pkg::ST_SCAN_RD;
      end
      lzwgc_pkg::ST_DECIDE: begin
        state_nxt = lzwgc_pkg::ST_TOK;
      end
      lzwgc_pkg::ST_TOK: begin
        // la_q holds the front lookahead byte
        if (8'(best_len_r) >= min_eff) begin
          tok_nxt.token_byte_count = lzwgc_pkg::TOK_MATCH;
          tok_nxt.first_byte       = marker_r;
          tok_nxt.second_byte      = best_off_r;
          tok_nxt.third_byte       = 8'(best_len_r);
          n_nxt                    = best_len_r;
        end else begin
          tok_nxt.token_byte_count = (la_q == marker_r) ? lzwgc_pkg::TOK_ESCAPE
                                                        : lzwgc_pkg::TOK_LITERAL;
          tok_nxt.first_byte       = la_q;
          tok_nxt.second_byte      = lzwgc_pkg::ESCAPE_CODE;
          tok_nxt.third_byte       = 8'd0;
          n_nxt                    = CNT_W'(1);
        end
        tok_nxt.block_done = last_r && (cnt_r == n_nxt);
        state_nxt = lzwgc_pkg::ST_EMIT;
      end
      lzwgc_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = tok_r;
          out_valid_nxt = 1'b1;
          state_nxt     = lzwgc_pkg::ST_COMMIT_RD;
        end
      end
      lzwgc_pkg::ST_COMMIT_RD: begin
        state_nxt = lzwgc_pkg::ST_COMMIT_WR;
      end
      lzwgc_pkg::ST_COMMIT_WR: begin
        // move one coded byte into history
        wp_nxt   = wp_r + 8'd1;
        if (fill_r < FILL_MAX) fill_nxt = fill_r + 8'd1;
        head_nxt = head_r + 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        n_nxt    = n_r - 1'b1;
        state_nxt = (n_r == CNT_W'(1)) ? lzwgc_pkg::ST_CHECK : lzwgc_pkg::ST_COMMIT_RD;
      end
      default: state_nxt = lzwgc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzwgc_pkg::ST_IDLE;
      marker_r    <= lzwgc_pkg::MARKER_RESET;
      min_match_r <= lzwgc_pkg::MIN_MATCH_RESET;
      wp_r        <= 8'd0;
      fill_r      <= 8'd0;
      head_r      <= '0;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      marker_r    <= marker_nxt;
      min_match_r <= min_match_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    d_r        <= d_nxt;
    len_r      <= len_nxt;
    best_len_r <= best_len_nxt;
    best_off_r <= best_off_nxt;
    n_r        <= n_nxt;
    tok_r      <= tok_nxt;
    out_r      <= out_nxt;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("lookahead count above capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("history fill above window");

  a_tok_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.token_byte_count != 2'd0)
    else $error("empty token presented");

  a_match_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.token_byte_count == lzwgc_pkg::TOK_MATCH)
      |-> (out_r.second_byte != 8'd0 && out_r.third_byte != 8'd0))
    else $error("match token with zero offset or length");

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzwgc_pkg::ST_COMMIT_WR) |-> (cnt_r != '0 && n_r != '0))
    else $error("commit with nothing queued");

endmodule

// ===== design/lzwgc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwgc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/lz_window_greedy_compressor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_window_greedy_compressor_unit_tb: self-checking bench for the compressor
// Blocks of bytes (repetitive patterns, runs, marker bytes and noise) are
// sent under random idling and a long output hold-off. A predictor of the
// greedy window matcher works out the tokens of every accepted word. Each
// token is checked field by field in arrival order. Registers change between
// blocks while the unit is idle.
// ----------------------------------------------------------------------------
module lz_window_greedy_compressor_unit_tb;

  localparam int WIN  = 255;
  localparam int MAXM = 32;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lzwgc_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lzwgc_pkg::out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic      cfg_index = lzwgc_pkg::CFG_MARKER_BYTE;
  logic [7:0] cfg_wdata = '0;

  lz_window_greedy_compressor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pending bytes and expected tokens
  lzwgc_pkg::in_word_t  byte_queue[$];
  lzwgc_pkg::out_word_t token_queue[$];
  int        errors = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  bit        hold_arm = 1'b0;

  // predictor state
  logic [7:0] hist[256];
  logic [7:0] wr_ptr;
  int         fill;
  logic [7:0] ahead[MAXM];
  int         ahead_cnt;
  logic [7:0] cur_marker;
  logic [6:0] cur_min;

  // code one token from the front of the lookahead
  task automatic code_token();
    int best_len, best_off, lim, len, minm, n;
    logic [7:0] idx;
    lzwgc_pkg::out_word_t t;
    best_len = 0;
    best_off = 0;
    for (int d = fill; d >= 1; d--) begin
      lim = d;
      if (lim > ahead_cnt) lim = ahead_cnt;
      len = 0;
      idx = wr_ptr - 8'(d);
      while (len < lim && hist[8'(idx + 8'(len))] == ahead[len]) len++;
      if (len > best_len) begin
        best_len = len;
        best_off = d;
      end
    end
    minm = (cur_min == 0) ? 1 : int'(cur_min);
    t = '0;
    if (best_len >= minm) begin
      t.token_byte_count = lzwgc_pkg::TOK_MATCH;
      t.first_byte = cur_marker;
      t.second_byte = 8'(best_off);
      t.third_byte = 8'(best_len);
      n = best_len;
    end else begin
      if (ahead[0] == cur_marker) begin
        t.token_byte_count = lzwgc_pkg::TOK_ESCAPE;
        t.first_byte = cur_marker;
        t.second_byte = lzwgc_pkg::ESCAPE_CODE;
      end else begin
        t.token_byte_count = lzwgc_pkg::TOK_LITERAL;
        t.first_byte = ahead[0];
      end
      n = 1;
    end
    token_queue.push_back(t);
    for (int i = 0; i < n; i++) begin
      hist[wr_ptr] = ahead[i];
      wr_ptr++;
      if (fill < WIN) fill++;
    end
    for (int i = 0; i < ahead_cnt - n; i++) ahead[i] = ahead[i + n];
    ahead_cnt -= n;
  endtask

  task automatic predict_tokens(lzwgc_pkg::in_word_t w);
    int base_cnt;
    base_cnt = token_queue.size();
    if (ahead_cnt < MAXM) begin
      ahead[ahead_cnt] = w.data_byte;
      ahead_cnt++;
    end
    if (!w.end_of_block) begin
      if (ahead_cnt >= MAXM) code_token();
    end else begin
      while (ahead_cnt > 0) code_token();
      if (token_queue.size() > base_cnt)
        token_queue[token_queue.size() - 1].block_done = 1'b1;
      fill = 0;
    end
  endtask

  // driver: offers bytes, predicts on each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_tokens(in_word);
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_word <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output hold-off, counted here
  int  hold_cnt = 0;
  bit  holding;
  assign holding = hold_arm && hold_cnt < 3000;
  always @(posedge clk) begin
    if (holding) hold_cnt <= hold_cnt + 1;
  end

  // monitor: checks each accepted token, drives out_stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (token_queue.size() == 0) begin
        $display("%0t: unexpected token %p", $time, out_word);
        errors++;
      end else begin
        lzwgc_pkg::out_word_t e;
        e = token_queue.pop_front();
        if (e.token_byte_count != out_word.token_byte_count ||
            e.first_byte != out_word.first_byte ||
            e.second_byte != out_word.second_byte ||
            e.third_byte != out_word.third_byte ||
            e.block_done != out_word.block_done) begin
          $display("%0t: token mismatch expected %p actual %p", $time, e, out_word);
          errors++;
        end
      end
    end
    out_stall <= holding || ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(logic idx, logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == lzwgc_pkg::CFG_MARKER_BYTE) cur_marker = v;
    else cur_min = v[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_byte(logic [7:0] b, bit last);
    lzwgc_pkg::in_word_t w;
    w.data_byte = b;
    w.end_of_block = last;
    byte_queue.push_back(w);
  endtask

  // one random block: mostly small alphabets or runs, some noise
  task automatic random_block();
    int len, kind;
    logic [7:0] sym[3];
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 30);
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) sym[i] = 8'($urandom);
    if ($urandom_range(3) == 0) sym[0] = cur_marker;
    for (int i = 0; i < len; i++) begin
      logic [7:0] b;
      if (kind < 6) b = sym[$urandom_range(2)];
      else if (kind < 8) b = (i % 4 == 3) ? 8'($urandom) : sym[i % 3];
      else if (kind == 8) b = sym[0];
      else b = 8'($urandom);
      push_byte(b, i == len - 1);
    end
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || in_valid || token_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    logic [7:0] mk[6];
    logic [6:0] mm[6];
    int cnt;
    mk = '{8'h00, 8'h41, 8'hFF, 8'hA5, 8'h00, 8'h7F};
    mm = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd33, 7'd2};
    wr_ptr = '0;
    fill = 0;
    ahead_cnt = 0;
    cur_marker = lzwgc_pkg::MARKER_RESET;
    cur_min = lzwgc_pkg::MIN_MATCH_RESET;
    send_idle = 6;
    recv_idle = 50;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, escape, repeats, lone-byte block
    push_byte(8'hFF, 0); push_byte(8'h00, 0); push_byte(8'hAA, 0); push_byte(8'h55, 0);
    for (int i = 0; i < 12; i++) push_byte(8'h61 + 8'(i % 3), 0);
    push_byte(8'hFF, 0); push_byte(8'h61, 1);
    push_byte(8'hFF, 1);
    push_byte(8'h00, 1);
    for (int i = 0; i < 5; i++) push_byte(8'h7E, i == 4);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(lzwgc_pkg::CFG_MARKER_BYTE, mk[p]);
      write_reg(lzwgc_pkg::CFG_MIN_MATCH, {1'b0, mm[p]});
      if (p == 2) begin
        send_idle = 50;
        recv_idle = 6;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 1) hold_arm = 1'b1;
      cnt = 0;
      while (cnt < 80) begin
        random_block();
        cnt = byte_queue.size() + cnt;
        while (byte_queue.size() > 0) @(posedge clk);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lzwgc_pkg.sv
design/lzwgc_ram.sv
design/lz_window_greedy_compressor_unit.sv
dv/lz_window_greedy_compressor_unit_tb.sv
